// ----- hw/rtl/ptld_pkg.sv -----
// types and constants shared by the point-to-line distance block
// used by ptld_sqrt and point_to_line_distance_3d; depends on nothing
package ptld_pkg;

    localparam int COORD_W    = 32;
    localparam int DIR_W      = 18;
    localparam int DIST_W     = 31;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int RAD_W      = 64;
    localparam int ROOT_W     = 32;
    localparam int ROOT_STEPS = 32;

    localparam logic [CFG_IDX_W-1:0] REG_DIR_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_Z = 3'd5;

    typedef struct packed {
        logic signed [COORD_W-1:0] pt_x;
        logic signed [COORD_W-1:0] pt_y;
        logic signed [COORD_W-1:0] pt_z;
    } ptld_point_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] proj_x;
        logic signed [COORD_W-1:0] proj_y;
        logic signed [COORD_W-1:0] proj_z;
        logic [DIST_W-1:0]         dist_res;
        logic                      overflow;
    } ptld_result_t;

    // fields that ride alongside the square root pipeline
    typedef struct packed {
        logic signed [COORD_W-1:0] proj_x;
        logic signed [COORD_W-1:0] proj_y;
        logic signed [COORD_W-1:0] proj_z;
        logic                      ovf;
        logic                      big;
    } ptld_side_t;

endpackage

// ----- hw/rtl/ptld_sqrt.sv -----
// pipelined integer square root, one result bit per register stage
// depends on ptld_pkg
module ptld_sqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [ptld_pkg::RAD_W-1:0] in_rad,
    input  ptld_pkg::ptld_side_t       in_side,
    output logic                       out_valid,
    output logic [ptld_pkg::ROOT_W-1:0] out_root,
    output ptld_pkg::ptld_side_t       out_side
);
    import ptld_pkg::*;

    logic [RAD_W-1:0] rem_reg  [0:ROOT_STEPS-1];
    logic [RAD_W-1:0] root_reg [0:ROOT_STEPS-1];
    ptld_side_t       side_reg [0:ROOT_STEPS-1];
    logic [ROOT_STEPS-1:0] vld_reg;

    genvar k;
    generate
        for (k = 0; k < ROOT_STEPS; k++) begin : g_step
            localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (RAD_W - 2 - 2 * k);
            logic [RAD_W-1:0] rem_in;
            logic [RAD_W-1:0] root_in;
            ptld_side_t       side_in;
            logic             vld_in;
            logic [RAD_W-1:0] trial;
            logic [RAD_W-1:0] rem_next;
            logic [RAD_W-1:0] root_next;

            if (k == 0) begin : g_first
                assign rem_in  = in_rad;
                assign root_in = '0;
                assign side_in = in_side;
                assign vld_in  = in_valid;
            end
            else begin : g_rest
                assign rem_in  = rem_reg[k-1];
                assign root_in = root_reg[k-1];
                assign side_in = side_reg[k-1];
                assign vld_in  = vld_reg[k-1];
            end

            always_comb
            begin
                trial = root_in + BIT;
                if (rem_in >= trial)
                begin
                    rem_next  = rem_in - trial;
                    root_next = (root_in >> 1) + BIT;
                end
                else
                begin
                    rem_next  = rem_in;
                    root_next = root_in >> 1;
                end
            end

            always_ff @(posedge clk)
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                side_reg[k] <= side_in;
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[k] <= 1'b0;
                else
                    vld_reg[k] <= vld_in;
            end
        end
    endgenerate

    assign out_valid = vld_reg[ROOT_STEPS-1];
    assign out_root  = root_reg[ROOT_STEPS-1][ROOT_W-1:0];
    assign out_side  = side_reg[ROOT_STEPS-1];

endmodule

// ----- hw/rtl/point_to_line_distance_3d.sv -----
// point-to-line projection and distance, top level
// depends on ptld_pkg and ptld_sqrt
//
// A point request is taken on any rising edge with start high and busy low;
// busy stays low, so a new point can be issued every cycle. Each request
// gives one result on result, marked by done for a single cycle, in request
// order. The receiver cannot hold results off and none is needed: the
// pipeline never stalls. The path holds eight arithmetic stages (offset,
// products, dot product with rounding, scaling, projection rounding,
// error, squaring, sum) and a 32-stage square root, one root bit per stage,
// then the output register.
// The line is configured over cfg_valid/cfg_ready/cfg_index/cfg_data;
// cfg_ready is always high and writes to unknown indexes are dropped.
// Change the line only while no request is in flight.
// Reset clears all in-flight requests and sets the direction to +x and the
// base point to the origin.
module point_to_line_distance_3d #(
    parameter int FRAC_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  ptld_pkg::ptld_point_t            point,
    output logic                             done,
    output ptld_pkg::ptld_result_t           result,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ptld_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ptld_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ptld_pkg::*;

    localparam int D_W    = COORD_W + 1;
    localparam int PROD_W = D_W + DIR_W;
    localparam int DOT_W  = PROD_W + 2;
    localparam int T_W    = DOT_W - FRAC_BITS;
    localparam int P_W    = T_W + DIR_W;
    localparam int O_W    = P_W - FRAC_BITS;
    localparam int Q_W    = ((O_W > COORD_W) ? O_W : COORD_W) + 1;
    localparam int E_W    = ((O_W > D_W) ? O_W : D_W) + 1;
    localparam int SQ_W   = 2 * DIST_W;
    localparam int LATENCY = 8 + ROOT_STEPS + 1;

    localparam logic signed [DOT_W-1:0] DOT_HALF = DOT_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [P_W-1:0]   P_HALF   = P_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [Q_W-1:0]   LIM_HI   = Q_W'(2147483647);
    localparam logic signed [Q_W-1:0]   LIM_LO   = ~LIM_HI;
    localparam logic [DIR_W-1:0]        DIR_ONE  = DIR_W'(1 << FRAC_BITS);

    // line registers
    logic signed [DIR_W-1:0]   dir_reg  [0:2];
    logic signed [COORD_W-1:0] base_reg [0:2];

    // arithmetic pipeline
    logic [7:0]                vld_reg;
    logic signed [D_W-1:0]     d1_reg   [0:2];
    logic signed [D_W-1:0]     d2_reg   [0:2];
    logic signed [D_W-1:0]     d3_reg   [0:2];
    logic signed [D_W-1:0]     d4_reg   [0:2];
    logic signed [D_W-1:0]     d5_reg   [0:2];
    logic signed [PROD_W-1:0]  prod_reg [0:2];
    logic signed [T_W-1:0]     t_reg;
    logic signed [P_W-1:0]     tp_reg   [0:2];
    logic signed [O_W-1:0]     off_reg  [0:2];
    logic [DIST_W-1:0]         ae_reg   [0:2];
    logic [SQ_W-1:0]           sq_reg   [0:2];
    logic [RAD_W-1:0]          sum_reg;
    ptld_side_t                side6_reg;
    ptld_side_t                side7_reg;
    ptld_side_t                side8_reg;

    logic signed [D_W-1:0]     d1_next   [0:2];
    logic signed [PROD_W-1:0]  prod_next [0:2];
    logic signed [DOT_W-1:0]   dot;
    logic signed [T_W-1:0]     t_next;
    logic signed [P_W-1:0]     tp_next   [0:2];
    logic signed [O_W-1:0]     off_next  [0:2];
    logic signed [Q_W-1:0]     q         [0:2];
    logic signed [COORD_W-1:0] q_sat     [0:2];
    logic signed [E_W-1:0]     e         [0:2];
    logic [E_W-1:0]            ae        [0:2];
    logic [DIST_W-1:0]         ae_next   [0:2];
    logic [SQ_W-1:0]           sq_next   [0:2];
    logic [RAD_W-1:0]          sum_next;
    ptld_side_t                side6_next;

    logic                      root_valid;
    logic [ROOT_W-1:0]         root;
    ptld_side_t                root_side;

    logic                      done_reg;
    ptld_result_t              result_reg;
    ptld_result_t              result_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg[0]  <= DIR_ONE;
            dir_reg[1]  <= '0;
            dir_reg[2]  <= '0;
            base_reg[0] <= '0;
            base_reg[1] <= '0;
            base_reg[2] <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_DIR_X:  dir_reg[0]  <= cfg_data[DIR_W-1:0];
                REG_DIR_Y:  dir_reg[1]  <= cfg_data[DIR_W-1:0];
                REG_DIR_Z:  dir_reg[2]  <= cfg_data[DIR_W-1:0];
                REG_BASE_X: base_reg[0] <= cfg_data[COORD_W-1:0];
                REG_BASE_Y: base_reg[1] <= cfg_data[COORD_W-1:0];
                REG_BASE_Z: base_reg[2] <= cfg_data[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        d1_next[0] = D_W'(point.pt_x) - D_W'(base_reg[0]);
        d1_next[1] = D_W'(point.pt_y) - D_W'(base_reg[1]);
        d1_next[2] = D_W'(point.pt_z) - D_W'(base_reg[2]);

        for (int i = 0; i < 3; i++)
            prod_next[i] = PROD_W'(d1_reg[i]) * PROD_W'(dir_reg[i]);

        // position along the line, rounded half up
        dot = DOT_W'(prod_reg[0]) + DOT_W'(prod_reg[1]) + DOT_W'(prod_reg[2]) + DOT_HALF;
        t_next = T_W'(dot >>> FRAC_BITS);

        for (int i = 0; i < 3; i++)
        begin
            tp_next[i]  = P_W'(t_reg) * P_W'(dir_reg[i]);
            off_next[i] = O_W'((tp_reg[i] + P_HALF) >>> FRAC_BITS);
        end

        for (int i = 0; i < 3; i++)
        begin
            q[i] = Q_W'(base_reg[i]) + Q_W'(off_reg[i]);
            if (q[i] > LIM_HI)
                q_sat[i] = LIM_HI[COORD_W-1:0];
            else if (q[i] < LIM_LO)
                q_sat[i] = LIM_LO[COORD_W-1:0];
            else
                q_sat[i] = q[i][COORD_W-1:0];
            // error vector uses the unclamped projection
            e[i]       = E_W'(off_reg[i]) - E_W'(d5_reg[i]);
            ae[i]      = e[i][E_W-1] ? E_W'(-e[i]) : E_W'(e[i]);
            ae_next[i] = ae[i][DIST_W-1:0];
        end

        side6_next.proj_x = q_sat[0];
        side6_next.proj_y = q_sat[1];
        side6_next.proj_z = q_sat[2];
        side6_next.ovf    = (q[0] > LIM_HI) || (q[0] < LIM_LO)
                         || (q[1] > LIM_HI) || (q[1] < LIM_LO)
                         || (q[2] > LIM_HI) || (q[2] < LIM_LO);
        side6_next.big    = (|ae[0][E_W-1:DIST_W]) || (|ae[1][E_W-1:DIST_W])
                         || (|ae[2][E_W-1:DIST_W]);

        for (int i = 0; i < 3; i++)
            sq_next[i] = SQ_W'(ae_reg[i]) * SQ_W'(ae_reg[i]);

        sum_next = RAD_W'(sq_reg[0]) + RAD_W'(sq_reg[1]) + RAD_W'(sq_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            d1_reg[i]   <= d1_next[i];
            d2_reg[i]   <= d1_reg[i];
            d3_reg[i]   <= d2_reg[i];
            d4_reg[i]   <= d3_reg[i];
            d5_reg[i]   <= d4_reg[i];
            prod_reg[i] <= prod_next[i];
            tp_reg[i]   <= tp_next[i];
            off_reg[i]  <= off_next[i];
            ae_reg[i]   <= ae_next[i];
            sq_reg[i]   <= sq_next[i];
        end
        t_reg     <= t_next;
        side6_reg <= side6_next;
        side7_reg <= side6_reg;
        side8_reg <= side7_reg;
        sum_reg   <= sum_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[6:0], start && !busy};
    end

    ptld_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld_reg[7]),
        .in_rad    (sum_reg),
        .in_side   (side8_reg),
        .out_valid (root_valid),
        .out_root  (root),
        .out_side  (root_side)
    );

    always_comb
    begin
        result_next.proj_x = root_side.proj_x;
        result_next.proj_y = root_side.proj_y;
        result_next.proj_z = root_side.proj_z;
        if (root_side.big || root[ROOT_W-1])
            result_next.dist_res = '1;
        else
            result_next.dist_res = root[DIST_W-1:0];
        result_next.overflow = root_side.ovf || root_side.big || root[ROOT_W-1];
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= root_valid;
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    // every request comes back after the fixed pipeline latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("request did not complete after pipeline latency");

    // no result without a request issued that many cycles before
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LATENCY))
        else $error("result strobe without a matching request");

    // a distance below full scale comes with overflow set only if a projection field is saturated
    a_dist_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.dist_res != '1)) |->
        ((result.overflow == 1'b0) || (result.proj_x == 32'sh7FFFFFFF)
         || (result.proj_x == 32'sh80000000) || (result.proj_y == 32'sh7FFFFFFF)
         || (result.proj_y == 32'sh80000000) || (result.proj_z == 32'sh7FFFFFFF)
         || (result.proj_z == 32'sh80000000)))
        else $error("overflow set with no saturated field");
`endif

endmodule

// ----- dv/tb_point_to_line_distance_3d.sv -----
// testbench for point_to_line_distance_3d: directed and random point requests checked
// against an in-bench projection and distance predictor; depends on ptld_pkg and the rtl
module tb_point_to_line_distance_3d;

    timeunit 1ns;
    timeprecision 1ps;

    import ptld_pkg::*;

    localparam int FRAC        = 16;
    localparam int DRAIN_EXTRA = 48;
    localparam int COORD_MAX   = 32'h7fff_ffff;
    localparam int COORD_MIN   = 32'h8000_0000;
    localparam int DIR_ONE     = 1 << FRAC;
    localparam int DIR_MAX     = 131071;
    localparam int DIR_MIN     = -131072;

    localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_HI = 3'd7;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    ptld_point_t            point = '0;
    logic                   done;
    ptld_result_t           result;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // line as the block should hold it
    logic signed [DIR_W-1:0]   line_dir [3];
    logic signed [COORD_W-1:0] line_base [3];

    ptld_result_t pending_results [$];

    int points_sent;
    int results_checked;
    int overflow_seen;
    int reg_writes;
    int line_changes;
    int fail_count;

    point_to_line_distance_3d #(
        .FRAC_BITS (FRAC)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .point     (point),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic ptld_result_t predict_projection(ptld_point_t p);
        longint       pc [3];
        longint       d [3];
        longint       off [3];
        longint       dot;
        longint       t;
        longint       q;
        longint       e;
        longint       half;
        logic [63:0]  ae;
        logic [63:0]  sum_sq;
        logic [63:0]  rem;
        logic [63:0]  root;
        logic [63:0]  bitv;
        logic [31:0]  proj [3];
        logic         big;
        logic         ovf;
        ptld_result_t r;
        half = longint'(1) << (FRAC - 1);
        pc[0] = longint'($signed(p.pt_x));
        pc[1] = longint'($signed(p.pt_y));
        pc[2] = longint'($signed(p.pt_z));
        dot = 0;
        for (int i = 0; i < 3; i++) begin
            d[i] = pc[i] - longint'(line_base[i]);
            dot += d[i] * longint'(line_dir[i]);
        end
        // round half up: add half an lsb, arithmetic shift floors
        t = (dot + half) >>> FRAC;
        big = 1'b0;
        ovf = 1'b0;
        sum_sq = '0;
        for (int i = 0; i < 3; i++) begin
            off[i] = (t * longint'(line_dir[i]) + half) >>> FRAC;
            q = longint'(line_base[i]) + off[i];
            if (q > longint'(COORD_MAX)) begin
                q = longint'(COORD_MAX);
                ovf = 1'b1;
            end
            if (q < longint'(COORD_MIN)) begin
                q = longint'(COORD_MIN);
                ovf = 1'b1;
            end
            proj[i] = q[31:0];
            // distance uses the unclamped projection
            e = off[i] - d[i];
            ae = (e < 0) ? -e : e;
            if (ae >= 64'h8000_0000)
                big = 1'b1;
            else
                sum_sq += ae * ae;
        end
        if (big) begin
            root = 64'h7fff_ffff;
            ovf = 1'b1;
        end else begin
            root = '0;
            rem = sum_sq;
            bitv = 64'h1 << 62;
            for (int i = 0; i < ROOT_STEPS; i++) begin
                if (rem >= root + bitv) begin
                    rem = rem - (root + bitv);
                    root = (root >> 1) + bitv;
                end else begin
                    root = root >> 1;
                end
                bitv = bitv >> 2;
            end
            if (root > 64'h7fff_ffff) begin
                root = 64'h7fff_ffff;
                ovf = 1'b1;
            end
        end
        r.proj_x = proj[0];
        r.proj_y = proj[1];
        r.proj_z = proj[2];
        r.dist_res = root[DIST_W-1:0];
        r.overflow = ovf;
        return r;
    endfunction

    function automatic logic [31:0] rand_coord();
        logic [31:0] c;
        case ($urandom_range(0, 7))
            0, 1, 2, 3: c = $urandom();
            4, 5:       c = $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
            6:          c = $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
            default:
            begin
                case ($urandom_range(0, 4))
                    0:       c = COORD_MAX;
                    1:       c = COORD_MIN;
                    2:       c = '0;
                    3:       c = '1;
                    default: c = 32'd1;
                endcase
            end
        endcase
        return c;
    endfunction

    // four in ten points close to the current line, the rest anywhere
    function automatic ptld_point_t rand_point();
        longint      s;
        longint      c;
        logic [31:0] crd [3];
        ptld_point_t p;
        if ($urandom_range(0, 9) < 4) begin
            s = longint'($urandom_range(0, 32'h0800_0000)) - 64'sh0400_0000;
            for (int i = 0; i < 3; i++) begin
                c = longint'(line_base[i]) + ((s * longint'(line_dir[i])) >>> FRAC)
                    + longint'($urandom_range(0, 8191)) - 4096;
                crd[i] = c[31:0];
            end
        end else begin
            for (int i = 0; i < 3; i++)
                crd[i] = rand_coord();
        end
        p.pt_x = crd[0];
        p.pt_y = crd[1];
        p.pt_z = crd[2];
        return p;
    endfunction

    task automatic send_point(input ptld_point_t p, input int idle_pct);
        start <= 1'b1;
        point <= p;
        do @(posedge clk); while (busy);
        pending_results.push_back(predict_projection(p));
        points_sent++;
        // each cycle idles with the given chance
        while ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic send_xyz(input int x, input int y, input int z);
        ptld_point_t p;
        p.pt_x = x;
        p.pt_y = y;
        p.pt_z = z;
        send_point(p, 0);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_EXTRA) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        reg_writes++;
        case (idx)
            REG_DIR_X:  line_dir[0] = data[DIR_W-1:0];
            REG_DIR_Y:  line_dir[1] = data[DIR_W-1:0];
            REG_DIR_Z:  line_dir[2] = data[DIR_W-1:0];
            REG_BASE_X: line_base[0] = data;
            REG_BASE_Y: line_base[1] = data;
            REG_BASE_Z: line_base[2] = data;
            default:    ;
        endcase
    endtask

    task automatic set_line(input int dx, input int dy, input int dz,
                            input int bx, input int by, input int bz);
        logic [31:0] dv [3];
        dv[0] = dx;
        dv[1] = dy;
        dv[2] = dz;
        wait_drained();
        // now and then put junk above the direction width
        for (int i = 0; i < 3; i++)
            if ($urandom_range(0, 3) == 0)
                dv[i] = {14'($urandom_range(0, 16383)), dv[i][DIR_W-1:0]};
        write_reg(REG_DIR_X, dv[0]);
        write_reg(REG_DIR_Y, dv[1]);
        write_reg(REG_DIR_Z, dv[2]);
        write_reg(REG_BASE_X, bx);
        write_reg(REG_BASE_Y, by);
        write_reg(REG_BASE_Z, bz);
        cfg_valid <= 1'b0;
        line_changes++;
    endtask

    task automatic randomize_line();
        int  dir [3];
        int  base [3];
        real v [3];
        real len;
        case ($urandom_range(0, 3))
            0:
            begin
                for (int i = 0; i < 3; i++)
                    v[i] = real'($urandom_range(0, 2000)) - 1000.0;
                len = $sqrt(v[0] * v[0] + v[1] * v[1] + v[2] * v[2]);
                if (len == 0.0) begin
                    v[0] = 1.0;
                    len = 1.0;
                end
                for (int i = 0; i < 3; i++)
                    dir[i] = $rtoi(v[i] / len * 65536.0);
            end
            1:
            begin
                dir = '{0, 0, 0};
                dir[$urandom_range(0, 2)] = $urandom_range(0, 1) ? DIR_ONE : -DIR_ONE;
            end
            2:
            begin
                for (int i = 0; i < 3; i++)
                    dir[i] = $urandom_range(0, 262143) - 131072;
            end
            default:
            begin
                for (int i = 0; i < 3; i++)
                    case ($urandom_range(0, 4))
                        0:       dir[i] = DIR_MIN;
                        1:       dir[i] = -DIR_ONE;
                        2:       dir[i] = 0;
                        3:       dir[i] = DIR_ONE;
                        default: dir[i] = DIR_MAX;
                    endcase
            end
        endcase
        for (int i = 0; i < 3; i++)
            base[i] = rand_coord();
        set_line(dir[0], dir[1], dir[2], base[0], base[1], base[2]);
    endtask

    task automatic test_reset_line();
        send_xyz(0, 0, 0);
        send_xyz(COORD_MAX, COORD_MAX, COORD_MAX);
        send_xyz(COORD_MIN, COORD_MIN, COORD_MIN);
        send_xyz(1, -1, 32'h1234_5678);
        send_xyz(COORD_MIN, 0, 0);
        send_xyz(0, COORD_MAX, COORD_MIN);
    endtask

    task automatic test_saturation();
        // non-unit direction pushes the projection past the coordinate range
        set_line(DIR_ONE, DIR_ONE, 0, 0, 0, 0);
        send_xyz(COORD_MAX, COORD_MAX, 0);
        send_xyz(COORD_MIN, COORD_MIN, 0);
        send_xyz(COORD_MAX, COORD_MIN, COORD_MAX);
        set_line(DIR_MAX, DIR_MIN, DIR_MAX, COORD_MAX, COORD_MIN, COORD_MAX);
        send_xyz(COORD_MIN, COORD_MAX, COORD_MIN);
        send_xyz(COORD_MAX, COORD_MAX, COORD_MAX);
        send_xyz(0, 0, 0);
        set_line(-DIR_ONE, 0, 0, COORD_MAX, COORD_MIN, COORD_MAX);
        send_xyz(COORD_MIN, COORD_MAX, COORD_MIN);
    endtask

    task automatic test_rounding();
        // half an lsb ties on both signs
        set_line(DIR_ONE / 2, 0, 0, 0, 0, 0);
        send_xyz(1, 0, 0);
        send_xyz(-1, 0, 0);
        send_xyz(3, 0, 0);
        send_xyz(-3, 0, 0);
        set_line(-DIR_ONE / 2, DIR_ONE / 2, 0, 1, -1, 0);
        send_xyz(0, 0, 0);
        send_xyz(2, -2, 5);
    endtask

    task automatic test_unused_index();
        set_line(0, DIR_ONE, 0, 100, 200, 300);
        @(posedge clk);
        write_reg(IDX_UNUSED_LO, $urandom());
        write_reg(IDX_UNUSED_HI, $urandom());
        cfg_valid <= 1'b0;
        send_xyz(5, 7, 9);
        send_xyz(COORD_MIN, COORD_MAX, 0);
    endtask

    task automatic test_random_stream(input int count, input int idle_pct);
        randomize_line();
        for (int n = 0; n < count; n++) begin
            if (n != 0 && n % 150 == 0)
                randomize_line();
            send_point(rand_point(), idle_pct);
        end
    endtask

    task automatic test_pause_for_drain();
        randomize_line();
        for (int n = 0; n < 60; n++) begin
            if (n == 30)
                wait_drained();
            send_point(rand_point(), 20);
        end
    endtask

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (want !== got) begin
            $display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk) begin : check_results
        ptld_result_t want;
        if (rst_n && done) begin
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result: expected none actual %h", $time, result);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                report_field("proj_x", want.proj_x, result.proj_x);
                report_field("proj_y", want.proj_y, result.proj_y);
                report_field("proj_z", want.proj_z, result.proj_z);
                report_field("dist_res", 32'(want.dist_res), 32'(result.dist_res));
                report_field("overflow", 32'(want.overflow), 32'(result.overflow));
                results_checked++;
                if (want.overflow)
                    overflow_seen++;
            end
        end
    end

    initial begin
        #3ms;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("** point_to_line_distance_3d: FAILED **");
        $finish;
    end

    initial begin
        line_dir = '{DIR_ONE, 0, 0};
        line_base = '{0, 0, 0};
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_line();
        test_saturation();
        test_rounding();
        test_unused_index();
        test_random_stream(600, 0);
        test_random_stream(600, 53);
        test_random_stream(600, 33);
        test_pause_for_drain();

        wait_drained();
        if (pending_results.size() != 0) begin
            $display("%0d results never arrived", pending_results.size());
            fail_count++;
        end
        $display("run covered %0d point requests and %0d results, %0d with saturation",
                 points_sent, results_checked, overflow_seen);
        $display("line reprogrammed %0d times over %0d register writes, %0d mismatches",
                 line_changes, reg_writes, fail_count);
        if (fail_count == 0)
            $display("** point_to_line_distance_3d: PASSED **");
        else
            $display("** point_to_line_distance_3d: FAILED **");
        $finish;
    end

endmodule

// ----- point_to_line_distance_3d.f -----
hw/rtl/ptld_pkg.sv
hw/rtl/ptld_sqrt.sv
hw/rtl/point_to_line_distance_3d.sv
dv/tb_point_to_line_distance_3d.sv
